// ----- sv/pnn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_pkg: shared types and constants for the polygon Newell normal block
// Status codes, fixed output widths and the control structs that pass
// between the top level, the edge accumulator and the normalisation unit.
// ----------------------------------------------------------------------------
package pnn_pkg;

   localparam int MINLEN_W     = 40;
   localparam int NORM_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int QUOT_W       = 15;  // quotient bits of one normal component
   localparam int MIN_VERTICES = 3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd2;

   localparam logic [NORM_W-1:0]   NORM_ONE     = 16'd16384;  // 1.0 in Q1.14
   localparam logic [MINLEN_W-1:0] MINLEN_RESET = 40'd1;

   typedef struct packed {
      logic start;
      logic clear;
   } mac_ctl_type;

   typedef struct packed {
      logic done;
      logic degenerate;
   } norm_stat_type;

endpackage
`default_nettype wire

// ----- sv/pnn_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_req_if: vertex input channel
// Valid/ready channel carrying one polygon vertex and its last-vertex flag.
// ----------------------------------------------------------------------------
interface pnn_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;
   logic                          last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface
`default_nettype wire

// ----- sv/pnn_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_rsp_if: normal result channel
// Valid/ready channel carrying the Q1.14 unit normal and its status code.
// ----------------------------------------------------------------------------
interface pnn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pnn_pkg::NORM_W-1:0]    normal_x;
   logic signed [pnn_pkg::NORM_W-1:0]    normal_y;
   logic signed [pnn_pkg::NORM_W-1:0]    normal_z;
   logic        [pnn_pkg::STATUS_W-1:0]  status;

   modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface
`default_nettype wire

// ----- sv/pnn_addsub.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_addsub: shared wide adder/subtractor
// Used by the normalisation sequencer for squaring, square root, the
// threshold compare and division. On subtract, carry high means a >= b.
// ----------------------------------------------------------------------------
module pnn_addsub #(
   parameter int W = 90
) (
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   input  wire logic         sub,
   output logic      [W-1:0] sum,
   output logic              carry
);
   logic [W:0] total;

   assign total = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{W{1'b0}}, sub};
   assign sum   = total[W-1:0];
   assign carry = total[W];

endmodule
`default_nettype wire

// ----- sv/pnn_edge_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_edge_mac: Newell edge accumulator
// Adds the three cross-product terms of one edge to the running sums, one
// term a cycle through a single multiplier, then a registered accumulate.
// ----------------------------------------------------------------------------
module pnn_edge_mac #(
   parameter int COORD_WIDTH = 16,
   parameter int SUM_W       = 44
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pnn_pkg::mac_ctl_type          ctl,
   input  wire logic signed [COORD_WIDTH-1:0] cur [3],
   input  wire logic signed [COORD_WIDTH-1:0] nxt [3],
   output logic signed      [SUM_W-1:0]       sums [3],
   output logic                               done
);
   localparam int FAC_W  = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * FAC_W;

   logic signed [COORD_WIDTH-1:0] cur_ff [3];
   logic signed [COORD_WIDTH-1:0] nxt_ff [3];
   logic        [1:0]             issue_ff, issue_in;
   logic                          busy_ff, busy_in;
   logic                          pvld_ff;
   logic        [1:0]             pidx_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [SUM_W-1:0]       sums_ff [3];
   logic                          done_ff;

   logic [COORD_WIDTH-1:0] dc, dn, sc, sn;
   logic [FAC_W-1:0]       fac_d, fac_s;

   // term x: (cy-ny)(cz+nz), y: (cz-nz)(cx+nx), z: (cx-nx)(cy+ny)
   always_comb begin
      case (issue_ff)
         2'd1: begin
            dc = cur_ff[2]; dn = nxt_ff[2]; sc = cur_ff[0]; sn = nxt_ff[0];
         end
         2'd2: begin
            dc = cur_ff[0]; dn = nxt_ff[0]; sc = cur_ff[1]; sn = nxt_ff[1];
         end
         default: begin
            dc = cur_ff[1]; dn = nxt_ff[1]; sc = cur_ff[2]; sn = nxt_ff[2];
         end
      endcase
      fac_d   = {dc[COORD_WIDTH-1], dc} - {dn[COORD_WIDTH-1], dn};
      fac_s   = {sc[COORD_WIDTH-1], sc} + {sn[COORD_WIDTH-1], sn};
      prod_in = $signed(fac_d) * $signed(fac_s);
   end

   always_comb begin
      issue_in = issue_ff;
      busy_in  = busy_ff;
      if (ctl.start) begin
         issue_in = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         issue_in = issue_ff + 2'd1;
         if (issue_ff == 2'd2) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 2'd0;
         busy_ff  <= 1'b0;
         pvld_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         busy_ff  <= busy_in;
         pvld_ff  <= busy_ff;
         done_ff  <= pvld_ff && (pidx_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cur_ff <= cur;
         nxt_ff <= nxt;
      end
      pidx_ff <= issue_ff;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (reset || ctl.clear) begin
            sums_ff[k] <= '0;
         end else if (pvld_ff && (pidx_ff == 2'(k))) begin
            sums_ff[k] <= sums_ff[k]
                        + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
   end

   assign sums = sums_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ----- sv/pnn_normalise.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pnn_normalise: length and unit normal sequencer
// Squares and sums the three magnitudes by shift-add, takes the integer
// square root bit by bit, checks the length threshold and divides each
// component by restoring division, all on one shared adder.
// ----------------------------------------------------------------------------
module pnn_normalise #(
   parameter int SUM_W = 44
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [SUM_W-1:0]             sums [3],
   input  wire logic [pnn_pkg::MINLEN_W-1:0]        min_length,
   output pnn_pkg::norm_stat_type                   stat,
   output logic signed [pnn_pkg::NORM_W-1:0]        normal [3]
);
   localparam int MAG_W = SUM_W;
   localparam int LEN_W = SUM_W + 1;
   localparam int S_W   = 2 * SUM_W + 2;
   localparam int CNT_W = $clog2(LEN_W);
   localparam int QW    = pnn_pkg::QUOT_W;

   localparam logic [2:0] N_IDLE   = 3'd0;
   localparam logic [2:0] N_SQUARE = 3'd1;
   localparam logic [2:0] N_ROOT   = 3'd2;
   localparam logic [2:0] N_CHECK  = 3'd3;
   localparam logic [2:0] N_LOAD   = 3'd4;
   localparam logic [2:0] N_DIVIDE = 3'd5;

   localparam logic [S_W-1:0] ONE_INIT = {{(S_W-1){1'b0}}, 1'b1} << (2 * (LEN_W - 1));

   logic [2:0]       state_ff, state_in;
   logic [1:0]       comp_ff, comp_in;
   logic [CNT_W-1:0] bit_ff, bit_in;
   logic [S_W-1:0]   acc_ff, acc_in;      // square sum, root remainder, quotient remainder
   logic [S_W-1:0]   mcand_ff, mcand_in;  // shifted multiplicand, then shifted divisor
   logic [MAG_W-1:0] mplier_ff, mplier_in;
   logic [S_W-1:0]   res_ff, res_in;
   logic [S_W-1:0]   one_ff, one_in;
   logic [QW-1:0]    quot_ff, quot_in;
   logic             degen_ff, degen_in;
   logic             done_ff, done_in;
   logic signed [pnn_pkg::NORM_W-1:0] normal_ff [3];
   logic                               nwr;
   logic signed [pnn_pkg::NORM_W-1:0] nval;

   logic [MAG_W-1:0] mags [3];
   logic [MAG_W-1:0] mag_cur, mag_next;
   logic             neg_cur;
   logic [S_W-1:0]   len_ext;
   logic [S_W-1:0]   add_a, add_b, add_sum;
   logic             add_sub, add_carry;
   logic [QW-1:0]    q_full;
   logic [pnn_pkg::NORM_W-1:0] q_sat;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mags[k] = sums[k][SUM_W-1] ? MAG_W'(-sums[k]) : MAG_W'(sums[k]);
      end
      case (comp_ff)
         2'd1:    begin mag_cur = mags[1]; mag_next = mags[2]; neg_cur = sums[1][SUM_W-1]; end
         2'd2:    begin mag_cur = mags[2]; mag_next = mags[2]; neg_cur = sums[2][SUM_W-1]; end
         default: begin mag_cur = mags[0]; mag_next = mags[1]; neg_cur = sums[0][SUM_W-1]; end
      endcase
   end

   assign len_ext = {{(S_W-LEN_W){1'b0}}, res_ff[LEN_W-1:0]};

   always_comb begin
      add_a   = acc_ff;
      add_b   = mcand_ff;
      add_sub = 1'b0;
      unique case (state_ff)
         N_ROOT: begin
            add_b   = res_ff | one_ff;
            add_sub = 1'b1;
         end
         N_CHECK: begin
            add_a   = {{(S_W-pnn_pkg::MINLEN_W){1'b0}}, min_length};
            add_b   = len_ext;
            add_sub = 1'b1;
         end
         N_LOAD: begin
            add_a = {{(S_W-MAG_W){1'b0}}, mag_cur} << QW;
            add_b = len_ext;
         end
         N_DIVIDE: add_sub = 1'b1;
         default: ;
      endcase
   end

   pnn_addsub #(.W(S_W)) u_addsub (
      .op_a  (add_a),
      .op_b  (add_b),
      .sub   (add_sub),
      .sum   (add_sum),
      .carry (add_carry)
   );

   // rounded quotient, limited to 1.0 and given the sign of the sum
   assign q_full = {quot_ff[QW-2:0], add_carry};
   always_comb begin
      q_sat = ({1'b0, q_full} > pnn_pkg::NORM_ONE) ? pnn_pkg::NORM_ONE : {1'b0, q_full};
      nval  = neg_cur ? $signed(-q_sat) : $signed(q_sat);
   end

   always_comb begin
      state_in  = state_ff;
      comp_in   = comp_ff;
      bit_in    = bit_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      res_in    = res_ff;
      one_in    = one_ff;
      quot_in   = quot_ff;
      degen_in  = degen_ff;
      done_in   = 1'b0;
      nwr       = 1'b0;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               comp_in   = 2'd0;
               bit_in    = '0;
               acc_in    = '0;
               mplier_in = mags[0];
               mcand_in  = {{(S_W-MAG_W){1'b0}}, mags[0]};
               degen_in  = 1'b0;
               state_in  = N_SQUARE;
            end
         end
         N_SQUARE: begin
            if (mplier_ff[0]) begin
               acc_in = add_sum;
            end
            mplier_in = mplier_ff >> 1;
            mcand_in  = mcand_ff << 1;
            bit_in    = bit_ff + CNT_W'(1);
            if (bit_ff == CNT_W'(MAG_W - 1)) begin
               bit_in = '0;
               if (comp_ff == 2'd2) begin
                  res_in   = '0;
                  one_in   = ONE_INIT;
                  state_in = N_ROOT;
               end else begin
                  comp_in   = comp_ff + 2'd1;
                  mplier_in = mag_next;
                  mcand_in  = {{(S_W-MAG_W){1'b0}}, mag_next};
               end
            end
         end
         N_ROOT: begin
            if (add_carry) begin
               acc_in = add_sum;
               res_in = (res_ff >> 1) | one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            bit_in = bit_ff + CNT_W'(1);
            if (bit_ff == CNT_W'(LEN_W - 1)) begin
               state_in = N_CHECK;
            end
         end
         N_CHECK: begin
            comp_in = 2'd0;
            if (add_carry) begin
               degen_in = 1'b1;
               done_in  = 1'b1;
               state_in = N_IDLE;
            end else begin
               state_in = N_LOAD;
            end
         end
         N_LOAD: begin
            acc_in   = add_sum;
            mcand_in = len_ext << QW;
            quot_in  = '0;
            bit_in   = '0;
            state_in = N_DIVIDE;
         end
         N_DIVIDE: begin
            if (add_carry) begin
               acc_in = add_sum;
            end
            quot_in  = q_full;
            mcand_in = mcand_ff >> 1;
            bit_in   = bit_ff + CNT_W'(1);
            if (bit_ff == CNT_W'(QW - 1)) begin
               nwr = 1'b1;
               if (comp_ff == 2'd2) begin
                  done_in  = 1'b1;
                  state_in = N_IDLE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = N_LOAD;
               end
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         comp_ff  <= 2'd0;
         bit_ff   <= '0;
         degen_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         bit_ff   <= bit_in;
         degen_ff <= degen_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      res_ff    <= res_in;
      one_ff    <= one_in;
      quot_ff   <= quot_in;
      for (int k = 0; k < 3; k++) begin
         if (nwr && (comp_ff == 2'(k))) begin
            normal_ff[k] <= nval;
         end
      end
   end

   assign stat.done       = done_ff;
   assign stat.degenerate = degen_ff;
   assign normal          = normal_ff;

endmodule
`default_nettype wire

// ----- sv/polygon_newell_normal.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_newell_normal: streaming Newell polygon normal
// Accumulates Newell sums over a vertex stream and gives one Q1.14 unit
// normal with a status code per polygon.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; the one flagged last_vertex closes the
// polygon and yields one result. Each vertex after the first occupies the
// block while its three cross-product terms go one a cycle through a single
// multiplier and are then accumulated. The last vertex adds the closing edge
// and then runs the normalisation sequencer, which uses one shared wide
// adder for everything: shift-add squaring of the sums, which are
// 2*COORD_WIDTH+2+clog2(MAX_VERTICES) bits wide, a bit-serial square root,
// one threshold compare and division. The input is not ready while any of
// this runs. A result waits in an output register, so the next polygon may
// start before it is taken. Polygons with fewer than three vertices, or
// with a length at or below min_length, give (0, 1.0, 0). Vertices beyond
// MAX_VERTICES are dropped, but their last flag still closes the polygon.
// ----------------------------------------------------------------------------
module polygon_newell_normal #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_WIDTH  = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pnn_req_if.sink                               req_ch,
   pnn_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [pnn_pkg::MINLEN_W-1:0]     csr_wr_data
);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W = 2 * COORD_WIDTH + 2 + $clog2(MAX_VERTICES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EDGE  = 3'd1;
   localparam logic [2:0] S_CLOSE = 3'd2;
   localparam logic [2:0] S_NORM  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in, cnt_inc;
   logic signed [COORD_WIDTH-1:0] first_ff [3], first_in [3];
   logic signed [COORD_WIDTH-1:0] prev_ff [3], prev_in [3];
   logic signed [COORD_WIDTH-1:0] vtx_ff [3], vtx_in [3];
   logic signed [COORD_WIDTH-1:0] req_v [3];
   logic                          last_ff, last_in;
   logic                          few_ff, few_in;
   logic [pnn_pkg::MINLEN_W-1:0]  min_length_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [pnn_pkg::NORM_W-1:0]  rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic        [pnn_pkg::STATUS_W-1:0] rsp_status_ff;

   pnn_pkg::mac_ctl_type          mac_ctl;
   logic signed [COORD_WIDTH-1:0] mac_cur [3], mac_nxt [3];
   logic signed [SUM_W-1:0]       sums [3];
   logic                          mac_done;
   logic                          norm_start;
   pnn_pkg::norm_stat_type        norm_stat;
   logic signed [pnn_pkg::NORM_W-1:0] normal [3];

   logic req_fire, rsp_fire, slot_free, emit;

   assign req_v[0] = req_ch.vertex_x;
   assign req_v[1] = req_ch.vertex_y;
   assign req_v[2] = req_ch.vertex_z;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign cnt_inc      = count_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      prev_in     = prev_ff;
      vtx_in      = vtx_ff;
      last_in     = last_ff;
      few_in      = few_ff;
      mac_ctl     = '0;
      mac_cur     = prev_ff;
      mac_nxt     = first_ff;
      norm_start  = 1'b0;
      emit        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               last_in = req_ch.last_vertex;
               vtx_in  = req_v;
               if (count_ff == '0) begin
                  first_in = req_v;
                  prev_in  = req_v;
                  count_in = CNT_W'(1);
                  if (req_ch.last_vertex) begin
                     few_in   = 1'b1;
                     state_in = S_EMIT;
                  end
               end else if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                  // vertex dropped; a last flag still closes the polygon
                  if (req_ch.last_vertex) begin
                     mac_ctl.start = 1'b1;
                     state_in      = S_CLOSE;
                  end
               end else begin
                  mac_ctl.start = 1'b1;
                  mac_nxt       = req_v;
                  state_in      = S_EDGE;
               end
            end
         end
         S_EDGE: begin
            if (mac_done) begin
               prev_in  = vtx_ff;
               count_in = cnt_inc;
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (cnt_inc < CNT_W'(pnn_pkg::MIN_VERTICES)) begin
                  few_in   = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  mac_ctl.start = 1'b1;
                  mac_cur       = vtx_ff;
                  state_in      = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            if (mac_done) begin
               norm_start = 1'b1;
               state_in   = S_NORM;
            end
         end
         S_NORM: begin
            if (norm_stat.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               emit          = 1'b1;
               mac_ctl.clear = 1'b1;
               count_in      = '0;
               few_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         few_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_length_ff <= pnn_pkg::MINLEN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         few_ff       <= few_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      prev_ff  <= prev_in;
      vtx_ff   <= vtx_in;
      last_ff  <= last_in;
      if (emit) begin
         if (few_ff || norm_stat.degenerate) begin
            rsp_nx_ff     <= '0;
            rsp_ny_ff     <= pnn_pkg::NORM_ONE;
            rsp_nz_ff     <= '0;
            rsp_status_ff <= few_ff ? pnn_pkg::STATUS_FEW : pnn_pkg::STATUS_DEGEN;
         end else begin
            rsp_nx_ff     <= normal[0];
            rsp_ny_ff     <= normal[1];
            rsp_nz_ff     <= normal[2];
            rsp_status_ff <= pnn_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.normal_x = rsp_nx_ff;
   assign rsp_ch.normal_y = rsp_ny_ff;
   assign rsp_ch.normal_z = rsp_nz_ff;
   assign rsp_ch.status   = rsp_status_ff;

   pnn_edge_mac #(
      .COORD_WIDTH (COORD_WIDTH),
      .SUM_W       (SUM_W)
   ) u_edge_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .cur   (mac_cur),
      .nxt   (mac_nxt),
      .sums  (sums),
      .done  (mac_done)
   );

   pnn_normalise #(
      .SUM_W (SUM_W)
   ) u_normalise (
      .clock      (clock),
      .reset      (reset),
      .start      (norm_start),
      .sums       (sums),
      .min_length (min_length_ff),
      .stat       (norm_stat),
      .normal     (normal)
   );

`ifndef ASSERT_OFF
   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == S_EDGE || state_ff == S_CLOSE))
      else $error("edge accumulator finished outside an edge or closing step");

   a_norm_done_state: assert property (@(posedge clock) disable iff (reset)
      norm_stat.done |-> (state_ff == S_NORM))
      else $error("normalisation finished while not awaited");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && slot_free) |=> rsp_valid_ff)
      else $error("result emitted but output register not valid");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond maximum");
`endif

endmodule
`default_nettype wire
